[sv/lvac_pkg.sv]
// ============================================================================
// lvac_pkg
// Shared types and constants for the label volume adjacency counter.
// ============================================================================
`default_nettype none

package lvac_pkg;

    // Sizes of the supported volume and label space.
    localparam int MAX_LABELS = 64;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COUNT_BITS = 32;

    localparam int LABEL_BITS  = $clog2(MAX_LABELS);
    localparam int X_BITS      = $clog2(MAX_WIDTH);
    localparam int Y_BITS      = $clog2(MAX_HEIGHT);
    localparam int DIM_BITS    = 7;
    localparam int CELL_BITS   = LABEL_BITS + 1;
    localparam int PLANE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PLANE_AW    = X_BITS + Y_BITS;
    localparam int PAIR_DEPTH  = MAX_LABELS * MAX_LABELS;
    localparam int PAIR_AW     = 2 * LABEL_BITS;

    // Neighbors checked per voxel: left, above and below.
    localparam int NBR_COUNT = 3;
    localparam int NBR_LEFT  = 0;
    localparam int NBR_ABOVE = 1;
    localparam int NBR_BELOW = 2;

    // Output queue that holds pair count results.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [1:0] {
        OPC_VOXEL = 2'd0,
        OPC_READ  = 2'd1,
        OPC_CLEAR = 2'd2,
        OPC_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_VOLUME_WIDTH  = 1'b0,
        REG_VOLUME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S1_VOXEL,
        S1_READ,
        S1_CLEAR
    } t_s1_kind;

    typedef struct packed {
        logic                  valid;
        logic [LABEL_BITS-1:0] label;
    } t_cell;

endpackage

`default_nettype wire

[sv/lvac_ram.sv]
// ============================================================================
// lvac_ram
// Generic single-write, single-read synchronous RAM with registered read.
// A read and a write to the same address in one cycle return the old data.
// ============================================================================
`default_nettype none

module lvac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/label_volume_adjacency_counter_core.sv]
// ============================================================================
// label_volume_adjacency_counter_core
// Counts 6-connected face adjacencies between differently labeled voxels of
// a raster-scanned 3D volume and answers pair count queries.
// ============================================================================
//
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  -----------------------------------
// input     in         i_valid / o_stall      i_opcode, i_label_valid,
//                                             i_voxel_label, i_row_label,
//                                             i_col_label
// output    out        o_valid / i_stall      o_pair_count
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A voxel transaction stays in the issue stage until each of its neighbors
// (0 to 3 of them) that forms a counted pair has been issued; the single
// read port of the count memory takes one read-modify-write per cycle. A
// read transaction passes through the issue stage, the count memory read
// and the output queue. A clear transaction waits for the count pipeline to
// drain and then sweeps all 4096 entries of the count memory. After reset
// the same clearing pass runs before the first transaction is accepted;
// configuration writes are taken at any time.
// Up to four read results may wait for the output side; beyond that the
// input channel stalls.
//
`default_nettype none

module label_volume_adjacency_counter_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Input channel
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [1:0]                           i_opcode,
    input  wire logic                                 i_label_valid,
    input  wire logic [lvac_pkg::LABEL_BITS-1:0]      i_voxel_label,
    input  wire logic [lvac_pkg::LABEL_BITS-1:0]      i_row_label,
    input  wire logic [lvac_pkg::LABEL_BITS-1:0]      i_col_label,
    // Output channel
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic      [lvac_pkg::COUNT_BITS-1:0]      o_pair_count,
    // Configuration channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [lvac_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [lvac_pkg::DIM_BITS-1:0]        i_cfg_data
);

    // Register values outside 1..max act as the nearest end of that range.
    function automatic logic [lvac_pkg::DIM_BITS-1:0] clamp_dim(
        input logic [lvac_pkg::DIM_BITS-1:0] v,
        input logic [lvac_pkg::DIM_BITS-1:0] vmax
    );
        logic [lvac_pkg::DIM_BITS-1:0] res;
        res = v;
        if (v == '0) begin
            res = lvac_pkg::DIM_BITS'(1);
        end else if (v > vmax) begin
            res = vmax;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lvac_pkg::DIM_BITS-1:0] r_cfg_width;
    logic [lvac_pkg::DIM_BITS-1:0] r_cfg_height;
    logic [lvac_pkg::DIM_BITS-1:0] dim_w;
    logic [lvac_pkg::DIM_BITS-1:0] dim_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= lvac_pkg::DIM_BITS'(lvac_pkg::MAX_WIDTH);
            r_cfg_height <= lvac_pkg::DIM_BITS'(lvac_pkg::MAX_HEIGHT);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (lvac_pkg::t_cfg_reg'(i_cfg_index))
                lvac_pkg::REG_VOLUME_WIDTH:  r_cfg_width  <= i_cfg_data;
                lvac_pkg::REG_VOLUME_HEIGHT: r_cfg_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign dim_w = clamp_dim(r_cfg_width, lvac_pkg::DIM_BITS'(lvac_pkg::MAX_WIDTH));
    assign dim_h = clamp_dim(r_cfg_height, lvac_pkg::DIM_BITS'(lvac_pkg::MAX_HEIGHT));

    // ------------------------------------------------------------------
    // Input acceptance
    // ------------------------------------------------------------------
    lvac_pkg::t_opcode opc;
    logic              in_fire;
    logic              vox_fire;
    logic              read_fire;
    logic              clear_fire;

    assign opc        = lvac_pkg::t_opcode'(i_opcode);
    assign in_fire    = i_valid && !o_stall;
    assign vox_fire   = in_fire && (opc == lvac_pkg::OPC_VOXEL);
    assign read_fire  = in_fire && (opc == lvac_pkg::OPC_READ);
    assign clear_fire = in_fire && (opc == lvac_pkg::OPC_CLEAR);

    // ------------------------------------------------------------------
    // Scan position. The position is settled at the moment a voxel is
    // accepted: a pending wrap (for example after the width shrank) is
    // applied first, then the position advances past this voxel.
    // ------------------------------------------------------------------
    logic [lvac_pkg::X_BITS-1:0] r_x;
    logic [lvac_pkg::Y_BITS-1:0] r_y;
    logic                        r_past;
    lvac_pkg::t_cell             r_left;

    lvac_pkg::t_cell               cur_cell;
    logic [lvac_pkg::DIM_BITS-1:0] x1;
    logic [lvac_pkg::DIM_BITS-1:0] y1;
    logic [lvac_pkg::DIM_BITS-1:0] y2;
    logic [lvac_pkg::DIM_BITS-1:0] x3;
    logic [lvac_pkg::DIM_BITS-1:0] y3;
    logic                          past1;
    logic [lvac_pkg::PLANE_AW-1:0] pos;
    logic [lvac_pkg::PLANE_AW-1:0] pos_above;
    logic [lvac_pkg::X_BITS-1:0]   n_x;
    logic [lvac_pkg::Y_BITS-1:0]   n_y;
    logic                          n_past;
    lvac_pkg::t_cell               n_left;

    assign cur_cell.valid = i_label_valid;
    assign cur_cell.label = i_voxel_label;

    always_comb begin
        // Wrap left over from an earlier size change.
        if ({1'b0, r_x} >= dim_w) begin
            x1 = '0;
            y1 = {1'b0, r_y} + lvac_pkg::DIM_BITS'(1);
        end else begin
            x1 = {1'b0, r_x};
            y1 = {1'b0, r_y};
        end
        if (y1 >= dim_h) begin
            y2    = '0;
            past1 = 1'b1;
        end else begin
            y2    = y1;
            past1 = r_past;
        end

        pos       = {y2[lvac_pkg::Y_BITS-1:0], x1[lvac_pkg::X_BITS-1:0]};
        pos_above = pos - lvac_pkg::PLANE_AW'(lvac_pkg::MAX_WIDTH);

        // Advance past the current voxel.
        x3 = x1 + lvac_pkg::DIM_BITS'(1);
        y3 = y2 + lvac_pkg::DIM_BITS'(1);
        if (x3 >= dim_w) begin
            n_x    = '0;
            n_left = '0;
            if (y3 >= dim_h) begin
                n_y    = '0;
                n_past = 1'b1;
            end else begin
                n_y    = y3[lvac_pkg::Y_BITS-1:0];
                n_past = past1;
            end
        end else begin
            n_x    = x3[lvac_pkg::X_BITS-1:0];
            n_y    = y2[lvac_pkg::Y_BITS-1:0];
            n_left = cur_cell;
            n_past = past1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_past <= 1'b0;
            r_left <= '0;
        end else if (clear_fire) begin
            r_x    <= '0;
            r_y    <= '0;
            r_past <= 1'b0;
            r_left <= '0;
        end else if (vox_fire) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_past <= n_past;
            r_left <= n_left;
        end
    end

    // ------------------------------------------------------------------
    // Plane buffer. Two copies are written identically so that the row
    // above and the slice below are read in the same cycle. The write of
    // the current voxel lands in the same cycle as the reads; the reads
    // return the old contents, which is what the slice-below lookup needs.
    // ------------------------------------------------------------------
    logic [lvac_pkg::CELL_BITS-1:0] q_above;
    logic [lvac_pkg::CELL_BITS-1:0] q_below;

    lvac_ram #(
        .WIDTH (lvac_pkg::CELL_BITS),
        .DEPTH (lvac_pkg::PLANE_DEPTH)
    ) u_plane_above (
        .i_clk   (i_clk),
        .i_we    (vox_fire),
        .i_waddr (pos),
        .i_wdata (cur_cell),
        .i_re    (vox_fire),
        .i_raddr (pos_above),
        .o_rdata (q_above)
    );

    lvac_ram #(
        .WIDTH (lvac_pkg::CELL_BITS),
        .DEPTH (lvac_pkg::PLANE_DEPTH)
    ) u_plane_below (
        .i_clk   (i_clk),
        .i_we    (vox_fire),
        .i_waddr (pos),
        .i_wdata (cur_cell),
        .i_re    (vox_fire),
        .i_raddr (pos),
        .o_rdata (q_below)
    );

    // ------------------------------------------------------------------
    // Issue stage. A voxel sits here while its counted pairs go out to the
    // count memory one per cycle. The plane read data stays valid because
    // the plane buffer is only read when a new voxel is accepted, and that
    // happens only as this stage empties.
    // ------------------------------------------------------------------
    logic                                  r_s1_vld;
    lvac_pkg::t_s1_kind                    r_s1_kind;
    lvac_pkg::t_cell                       r_s1_cur;
    lvac_pkg::t_cell                       r_s1_left;
    logic [lvac_pkg::NBR_COUNT-1:0]        r_s1_flags;
    logic [lvac_pkg::NBR_COUNT-1:0]        r_s1_done;
    logic [lvac_pkg::PAIR_AW-1:0]          r_s1_ridx;
    logic                                  r_s1_diag;

    lvac_pkg::t_cell                       nbr     [lvac_pkg::NBR_COUNT];
    logic [lvac_pkg::NBR_COUNT-1:0]        cand;
    logic [lvac_pkg::PAIR_AW-1:0]          cand_idx [lvac_pkg::NBR_COUNT];
    logic [lvac_pkg::NBR_COUNT-1:0]        pend;
    logic [lvac_pkg::NBR_COUNT-1:0]        pick;
    logic [lvac_pkg::PAIR_AW-1:0]          pick_idx;

    logic                                  s1_last;
    logic                                  s1_free;
    logic                                  iss_vld;
    logic                                  iss_read;
    logic                                  iss_diag;
    logic [lvac_pkg::PAIR_AW-1:0]          iss_idx;
    logic                                  clr_start;

    logic                                  r_c_vld;
    logic                                  r_clr;
    logic [lvac_pkg::OUTQ_CW-1:0]          r_rd_cnt;

    // Counts are symmetric, so each pair lives at the entry with the
    // smaller label in the upper index bits.
    always_comb begin
        nbr[lvac_pkg::NBR_LEFT]  = r_s1_left;
        nbr[lvac_pkg::NBR_ABOVE] = lvac_pkg::t_cell'(q_above);
        nbr[lvac_pkg::NBR_BELOW] = lvac_pkg::t_cell'(q_below);
        for (int k = 0; k < lvac_pkg::NBR_COUNT; k++) begin
            cand[k] = r_s1_flags[k] && r_s1_cur.valid && nbr[k].valid
                      && (nbr[k].label != r_s1_cur.label);
            if (r_s1_cur.label < nbr[k].label) begin
                cand_idx[k] = {r_s1_cur.label, nbr[k].label};
            end else begin
                cand_idx[k] = {nbr[k].label, r_s1_cur.label};
            end
        end
        pend = cand & ~r_s1_done;
        pick = pend & (~pend + lvac_pkg::NBR_COUNT'(1));
        if (pick[lvac_pkg::NBR_LEFT]) begin
            pick_idx = cand_idx[lvac_pkg::NBR_LEFT];
        end else if (pick[lvac_pkg::NBR_ABOVE]) begin
            pick_idx = cand_idx[lvac_pkg::NBR_ABOVE];
        end else begin
            pick_idx = cand_idx[lvac_pkg::NBR_BELOW];
        end
    end

    always_comb begin
        s1_last   = 1'b0;
        iss_vld   = 1'b0;
        iss_read  = 1'b0;
        iss_diag  = 1'b0;
        iss_idx   = pick_idx;
        clr_start = 1'b0;
        if (r_s1_vld) begin
            case (r_s1_kind)
                lvac_pkg::S1_VOXEL: begin
                    iss_vld = |pend;
                    s1_last = ((pend & ~pick) == '0);
                end
                lvac_pkg::S1_READ: begin
                    iss_vld  = 1'b1;
                    iss_read = 1'b1;
                    iss_diag = r_s1_diag;
                    iss_idx  = r_s1_ridx;
                    s1_last  = 1'b1;
                end
                lvac_pkg::S1_CLEAR: begin
                    // Earlier updates must land before the sweep starts.
                    if (!r_c_vld) begin
                        clr_start = 1'b1;
                        s1_last   = 1'b1;
                    end
                end
                default: begin
                    s1_last = 1'b1;
                end
            endcase
        end
        s1_free = !r_s1_vld || s1_last;
    end

    assign o_stall = r_clr || clr_start || !s1_free
                     || (r_rd_cnt == lvac_pkg::OUTQ_CW'(lvac_pkg::OUTQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_fire) begin
            r_s1_vld <= (opc != lvac_pkg::OPC_NOP);
        end else if (s1_last) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_done <= '0;
            case (opc)
                lvac_pkg::OPC_VOXEL: r_s1_kind <= lvac_pkg::S1_VOXEL;
                lvac_pkg::OPC_READ:  r_s1_kind <= lvac_pkg::S1_READ;
                default:             r_s1_kind <= lvac_pkg::S1_CLEAR;
            endcase
            r_s1_cur   <= cur_cell;
            r_s1_left  <= r_left;
            r_s1_flags <= {past1, (y2 != '0), (x1 != '0)};
            if (i_row_label < i_col_label) begin
                r_s1_ridx <= {i_row_label, i_col_label};
            end else begin
                r_s1_ridx <= {i_col_label, i_row_label};
            end
            r_s1_diag <= (i_row_label == i_col_label);
        end else begin
            r_s1_done <= r_s1_done | pick;
        end
    end

    // ------------------------------------------------------------------
    // Count memory stage. The read issued above returns here from the
    // registered read port; increments are written back at once. A back-to-back update of
    // the same entry reads stale data, so the last write is forwarded.
    // ------------------------------------------------------------------
    logic                            r_c_read;
    logic                            r_c_diag;
    logic [lvac_pkg::PAIR_AW-1:0]    r_c_idx;

    logic                            r_wr_vld;
    logic [lvac_pkg::PAIR_AW-1:0]    r_wr_idx;
    logic [lvac_pkg::COUNT_BITS-1:0] r_wr_val;

    logic [lvac_pkg::PAIR_AW-1:0]    r_clr_addr;

    logic [lvac_pkg::COUNT_BITS-1:0] cnt_q;
    logic [lvac_pkg::COUNT_BITS-1:0] c_data;
    logic [lvac_pkg::COUNT_BITS-1:0] c_inc;
    logic                            cnt_we;
    logic [lvac_pkg::PAIR_AW-1:0]    cnt_waddr;
    logic [lvac_pkg::COUNT_BITS-1:0] cnt_wdata;
    logic                            push;
    logic [lvac_pkg::COUNT_BITS-1:0] push_data;

    always_comb begin
        if (r_wr_vld && (r_wr_idx == r_c_idx)) begin
            c_data = r_wr_val;
        end else begin
            c_data = cnt_q;
        end
        // Saturate at the all-ones value.
        if (&c_data) begin
            c_inc = c_data;
        end else begin
            c_inc = c_data + lvac_pkg::COUNT_BITS'(1);
        end
        if (r_clr) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr_addr;
            cnt_wdata = '0;
        end else begin
            cnt_we    = r_c_vld && !r_c_read;
            cnt_waddr = r_c_idx;
            cnt_wdata = c_inc;
        end
        push      = r_c_vld && r_c_read;
        push_data = r_c_diag ? '0 : c_data;
    end

    lvac_ram #(
        .WIDTH (lvac_pkg::COUNT_BITS),
        .DEPTH (lvac_pkg::PAIR_DEPTH)
    ) u_count (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (iss_vld),
        .i_raddr (iss_idx),
        .o_rdata (cnt_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld  <= 1'b0;
            r_wr_vld <= 1'b0;
        end else begin
            r_c_vld  <= iss_vld;
            r_wr_vld <= cnt_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_read <= iss_read;
        r_c_diag <= iss_diag;
        r_c_idx  <= iss_idx;
        r_wr_idx <= cnt_waddr;
        r_wr_val <= cnt_wdata;
    end

    // Clearing pass: one entry per cycle, after reset and on a clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (clr_start) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + lvac_pkg::PAIR_AW'(1);
            if (&r_clr_addr) begin
                r_clr <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output queue. Reads in flight are counted from acceptance, so the
    // queue can never overflow while the output side stalls.
    // ------------------------------------------------------------------
    logic [lvac_pkg::COUNT_BITS-1:0] r_q_mem [lvac_pkg::OUTQ_DEPTH];
    logic [lvac_pkg::OUTQ_AW-1:0]    r_q_wp;
    logic [lvac_pkg::OUTQ_AW-1:0]    r_q_rp;
    logic [lvac_pkg::OUTQ_CW-1:0]    r_q_cnt;
    logic                            pop;

    assign o_valid      = (r_q_cnt != '0);
    assign o_pair_count = r_q_mem[r_q_rp];
    assign pop          = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mem[r_q_wp] <= push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp   <= '0;
            r_q_rp   <= '0;
            r_q_cnt  <= '0;
            r_rd_cnt <= '0;
        end else begin
            if (push) begin
                r_q_wp <= r_q_wp + lvac_pkg::OUTQ_AW'(1);
            end
            if (pop) begin
                r_q_rp <= r_q_rp + lvac_pkg::OUTQ_AW'(1);
            end
            if (push && !pop) begin
                r_q_cnt <= r_q_cnt + lvac_pkg::OUTQ_CW'(1);
            end else if (!push && pop) begin
                r_q_cnt <= r_q_cnt - lvac_pkg::OUTQ_CW'(1);
            end
            if (read_fire && !pop) begin
                r_rd_cnt <= r_rd_cnt + lvac_pkg::OUTQ_CW'(1);
            end else if (!read_fire && pop) begin
                r_rd_cnt <= r_rd_cnt - lvac_pkg::OUTQ_CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[verif/lvac_adjacency_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// lvac_adjacency_checker
// Watches the input, output and configuration channels of the adjacency
// counter, keeps its own copy of the scan state and pair counts, and checks
// every pair count result against the oldest outstanding prediction.
// ============================================================================

module lvac_adjacency_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    input  wire logic                                 i_in_stall,
    input  wire logic [1:0]                           i_opcode,
    input  wire logic                                 i_label_valid,
    input  wire logic [lvac_pkg::LABEL_BITS-1:0]      i_voxel_label,
    input  wire logic [lvac_pkg::LABEL_BITS-1:0]      i_row_label,
    input  wire logic [lvac_pkg::LABEL_BITS-1:0]      i_col_label,
    input  wire logic                                 i_out_valid,
    input  wire logic                                 i_out_stall,
    input  wire logic [lvac_pkg::COUNT_BITS-1:0]      i_pair_count,
    input  wire logic                                 i_cfg_valid,
    input  wire logic                                 i_cfg_ready,
    input  wire logic [lvac_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [lvac_pkg::DIM_BITS-1:0]        i_cfg_data,
    output int                                        o_error_count,
    output int                                        o_pending
);

    import lvac_pkg::*;

    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;
    t_cell                 plane [PLANE_DEPTH];
    logic [COUNT_BITS-1:0] pair_counts [PAIR_DEPTH];
    t_cell                 left_cell;
    int unsigned           scan_x;
    int unsigned           scan_y;
    bit                    below_valid;
    logic [COUNT_BITS-1:0] expected_counts [$];
    int                    mismatches = 0;

    // A size of zero behaves as one, anything past the maximum as the maximum.
    function automatic int unsigned effective_dim(input logic [DIM_BITS-1:0] value,
                                                  input int unsigned limit);
        if (value == '0) return 1;
        if (32'(value) > limit) return limit;
        return 32'(value);
    endfunction

    function automatic void bump_count(input logic [PAIR_AW-1:0] index);
        if (pair_counts[index] != '1) pair_counts[index] = pair_counts[index] + COUNT_BITS'(1);
    endfunction

    function automatic void tally_pair(input t_cell cur, input t_cell other);
        if (!cur.valid || !other.valid || cur.label == other.label) return;
        bump_count({cur.label, other.label});
        bump_count({other.label, cur.label});
    endfunction

    function automatic void restart_scan();
        left_cell   = '0;
        scan_x      = 0;
        scan_y      = 0;
        below_valid = 1'b0;
    endfunction

    function automatic void scan_voxel(input t_cell cur);
        int unsigned w;
        int unsigned h;
        int unsigned pos;
        w = effective_dim(width_reg, MAX_WIDTH);
        h = effective_dim(height_reg, MAX_HEIGHT);
        // A size written mid-scan may leave the position outside the plane.
        if (scan_x >= w) begin
            scan_x = 0;
            scan_y++;
        end
        if (scan_y >= h) begin
            scan_y      = 0;
            below_valid = 1'b1;
        end
        pos = scan_y * MAX_WIDTH + scan_x;
        if (scan_x > 0) tally_pair(cur, left_cell);
        if (scan_y > 0) tally_pair(cur, plane[pos - MAX_WIDTH]);
        if (below_valid) tally_pair(cur, plane[pos]);
        plane[pos] = cur;
        left_cell  = cur;
        scan_x++;
        if (scan_x >= w) begin
            scan_x    = 0;
            left_cell = '0;
            scan_y++;
            if (scan_y >= h) begin
                scan_y      = 0;
                below_valid = 1'b1;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        logic [COUNT_BITS-1:0] want;
        t_cell                 cur;
        if (!i_rst_n) begin
            width_reg  = DIM_BITS'(MAX_WIDTH);
            height_reg = DIM_BITS'(MAX_HEIGHT);
            foreach (plane[i]) plane[i] = '0;
            foreach (pair_counts[i]) pair_counts[i] = '0;
            restart_scan();
            expected_counts.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_VOLUME_WIDTH:  width_reg = i_cfg_data;
                    REG_VOLUME_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (t_opcode'(i_opcode))
                    OPC_VOXEL: begin
                        cur.valid = i_label_valid;
                        cur.label = i_voxel_label;
                        scan_voxel(cur);
                    end
                    OPC_READ: begin
                        if (i_row_label == i_col_label) expected_counts.push_back('0);
                        else expected_counts.push_back(pair_counts[{i_row_label, i_col_label}]);
                    end
                    OPC_CLEAR: begin
                        foreach (pair_counts[i]) pair_counts[i] = '0;
                        restart_scan();
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_counts.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected pair_count result, expected none, got %0d",
                             $time, i_pair_count);
                end else begin
                    want = expected_counts.pop_front();
                    if (i_pair_count !== want) begin
                        mismatches++;
                        $display("%0t: pair_count mismatch, expected %0d, got %0d",
                                 $time, want, i_pair_count);
                    end
                end
            end
        end
        o_pending     <= expected_counts.size();
        o_error_count <= mismatches;
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives voxel, read, clear and idle transactions into the adjacency counter
// with random gaps and stalls on both channels, steps through several volume
// sizes, and reports the verdict from the checker's error count.
// ============================================================================

module testbench;

    import lvac_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // covers a clear sweep several times over
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off to fill the block
    localparam int SETTLE_CYCLES  = 16;     // lets a voxel finish its count updates
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 90;
    localparam int BURST_READS    = 24;
    localparam int PALETTE_SIZE   = 4;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic [1:0]              in_opcode   = OPC_NOP;
    logic                    label_valid = 1'b0;
    logic [LABEL_BITS-1:0]   voxel_label = '0;
    logic [LABEL_BITS-1:0]   row_label   = '0;
    logic [LABEL_BITS-1:0]   col_label   = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [COUNT_BITS-1:0]   pair_count;
    logic                    cfg_valid   = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index   = REG_VOLUME_WIDTH;
    logic [DIM_BITS-1:0]     cfg_data    = '0;

    int                      error_count;
    int                      pending;
    int                      tx_idle_pct  = 0;
    int                      rx_stall_pct = 0;
    bit                      hold_toggle  = 1'b0;
    bit                      hold_seen    = 1'b0;
    int                      hold_left    = 0;
    int                      quiet_cycles = 0;
    logic [LABEL_BITS-1:0]   palette [PALETTE_SIZE];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    label_volume_adjacency_counter_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_opcode      (in_opcode),
        .i_label_valid (label_valid),
        .i_voxel_label (voxel_label),
        .i_row_label   (row_label),
        .i_col_label   (col_label),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_pair_count  (pair_count),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    lvac_adjacency_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_opcode      (in_opcode),
        .i_label_valid (label_valid),
        .i_voxel_label (voxel_label),
        .i_row_label   (row_label),
        .i_col_label   (col_label),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_pair_count  (pair_count),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // The result side stalls at random. A flip of hold_toggle starts a long
    // hold-off, counted here, during which the sender keeps offering reads so
    // that the result queue fills and the block stalls its input.
    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // The watchdog ends the run once no transaction has moved on any channel
    // for too long. A clear sweep is the longest legitimate quiet stretch.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one transaction after a random gap and returns at the edge that
    // accepts it. Valid stays high when the next call follows at once.
    task automatic send_item(input t_opcode op, input logic lv,
                             input logic [LABEL_BITS-1:0] voxel, row, col);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_opcode   <= op;
        label_valid <= lv;
        voxel_label <= voxel;
        row_label   <= row;
        col_label   <= col;
        do @(posedge clk); while (in_stall);
    endtask

    // Writes both size registers back to back, then drops the write valid.
    task automatic set_volume(input logic [DIM_BITS-1:0] new_width, new_height);
        cfg_valid <= 1'b1;
        cfg_index <= REG_VOLUME_WIDTH;
        cfg_data  <= new_width;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_VOLUME_HEIGHT;
        cfg_data  <= new_height;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering input and waits until every read has been answered and
    // any voxel still updating counts has had time to finish.
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly labels from a small per-phase set so that pairs repeat and the
    // counts grow; now and then any label at all.
    function automatic logic [LABEL_BITS-1:0] palette_label();
        if ($urandom_range(99) < 85) return palette[$urandom_range(PALETTE_SIZE - 1)];
        return LABEL_BITS'($urandom());
    endfunction

    initial begin
        int unsigned         pick;
        t_opcode             op;
        logic [DIM_BITS-1:0] new_w;
        logic [DIM_BITS-1:0] new_h;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The sizes go in while the post-reset clearing pass
        // runs, with the scan still at its first position.
        tx_idle_pct  = 33;
        rx_stall_pct = 66;
        set_volume(7'd2, 7'd2);

        // Two full 2x2 slices, so every neighbor direction is hit. The
        // unlabeled voxel carries label 63 to show that its label is ignored.
        send_item(OPC_VOXEL, 1'b1, 6'd0,  6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd63, 6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd5,  6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd63, 6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd63, 6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b0, 6'd63, 6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd0,  6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd5,  6'd0, 6'd0);

        // Shrink to zero by zero (acts as 1x1) without restarting the scan.
        // Every plane entry of the new size was written by the slices above.
        quiesce();
        set_volume(7'd0, 7'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd5, 6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd0, 6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd0, 6'd0, 6'd0);

        // Both orders of a pair, the diagonal, and the pair of labels 5 and 0.
        send_item(OPC_READ, 1'b0, 6'd0, 6'd0,  6'd63);
        send_item(OPC_READ, 1'b0, 6'd0, 6'd63, 6'd0);
        send_item(OPC_READ, 1'b0, 6'd0, 6'd63, 6'd63);
        send_item(OPC_READ, 1'b0, 6'd0, 6'd5,  6'd0);
        send_item(OPC_NOP,  1'b1, 6'd63, 6'd63, 6'd63);
        send_item(OPC_CLEAR, 1'b0, 6'd0, 6'd0, 6'd0);
        send_item(OPC_READ, 1'b0, 6'd0, 6'd0,  6'd63);

        // Oversized registers act as the maximum plane.
        quiesce();
        set_volume(7'd127, 7'd127);
        send_item(OPC_VOXEL, 1'b1, 6'd0,  6'd0, 6'd0);
        send_item(OPC_VOXEL, 1'b1, 6'd63, 6'd0, 6'd0);
        send_item(OPC_READ,  1'b0, 6'd0,  6'd63, 6'd0);

        // Random part. Each phase sets a size, restarts the scan with a clear
        // so no plane entry is read before it is written, then mixes voxels
        // with reads and the odd clear or idle opcode.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            quiesce();
            if (phase < 4) begin
                tx_idle_pct  = 33;
                rx_stall_pct = 66;
            end else if (phase < 8) begin
                tx_idle_pct  = 66;
                rx_stall_pct = 33;
            end else begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            case (phase)
                0: begin
                    new_w = 7'd1;
                    new_h = 7'd1;
                end
                1: begin
                    new_w = 7'd127;
                    new_h = 7'd2;
                end
                2: begin
                    new_w = 7'd2;
                    new_h = 7'd0;
                end
                4: begin
                    new_w = 7'd64;
                    new_h = 7'd64;
                end
                5: begin
                    new_w = 7'd65;
                    new_h = 7'd3;
                end
                default: begin
                    new_w = DIM_BITS'($urandom_range(8, 1));
                    new_h = DIM_BITS'($urandom_range(5, 1));
                end
            endcase
            foreach (palette[i]) palette[i] = LABEL_BITS'($urandom());
            set_volume(new_w, new_h);
            send_item(OPC_CLEAR, 1'b0, palette_label(), palette_label(), palette_label());

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 62) op = OPC_VOXEL;
                else if (pick < 94) op = OPC_READ;
                else if (pick < 98) op = OPC_NOP;
                else op = OPC_CLEAR;
                send_item(op, ($urandom_range(99) < 80), palette_label(), palette_label(),
                          palette_label());
            end

            // Back-to-back reads against a long hold-off on the result side.
            if (phase == 8) begin
                hold_toggle <= ~hold_toggle;
                for (int n = 0; n < BURST_READS; n++) begin
                    send_item(OPC_READ, 1'b0, palette_label(), palette_label(),
                              palette_label());
                end
            end
        end

        quiesce();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
